// ===== src/lflt_pkg.sv =====
`default_nettype none

package lflt_pkg;

    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned IP_W    = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MS_W    = 20;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned SLOT_W  = 3;

    localparam logic [CNT_W-1:0] FAIL_SAT = 8'hFF;

    localparam logic [ADDR_W-1:0] ADDR_PENALTY = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_STALE   = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_LIMIT   = 4'h8;

    localparam logic [MS_W-1:0]  PENALTY_RST = 20'd5000;
    localparam logic [MS_W-1:0]  STALE_RST   = 20'd60000;
    localparam logic [CNT_W-1:0] LIMIT_RST   = 8'd3;

    typedef enum logic [1:0] {
        VERDICT_OK     = 2'd0,
        VERDICT_WRONG  = 2'd1,
        VERDICT_LOCKED = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic [MS_W-1:0]  penalty_ms;
        logic [MS_W-1:0]  stale_ms;
        logic [CNT_W-1:0] fail_limit;
    } t_cfg;

    typedef struct packed {
        logic [IP_W-1:0]   addr;
        logic [CNT_W-1:0]  failures;
        logic [TIME_W-1:0] last_fail;
    } t_entry;

endpackage

`default_nettype wire

// ===== src/lflt_cfg.sv =====
`default_nettype none

module lflt_cfg
    import lflt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.penalty_ms <= PENALTY_RST;
            r_cfg.stale_ms   <= STALE_RST;
            r_cfg.fail_limit <= LIMIT_RST;
        end else if (wr_en) begin
            case (paddr)
                ADDR_PENALTY: r_cfg.penalty_ms <= pwdata[MS_W-1:0];
                ADDR_STALE:   r_cfg.stale_ms   <= pwdata[MS_W-1:0];
                ADDR_LIMIT:   r_cfg.fail_limit <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_PENALTY: prdata = DATA_W'(r_cfg.penalty_ms);
            ADDR_STALE:   prdata = DATA_W'(r_cfg.stale_ms);
            ADDR_LIMIT:   prdata = DATA_W'(r_cfg.fail_limit);
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/login_failure_lockout_table.sv =====
// scan: a first pass looks for the client address; if none matches, a second pass
// claims the first entry that is empty or stale; with no entry available the verdict
// is given without a table write; a new attempt is accepted only while idle, after the
// last word is loaded; one subtractor walks the entries (registered read, then check)
// reset: synchronous, clears the per-entry valid bits so the table reads as zero,
// loads the register defaults; no clearing pass
`default_nettype none

module login_failure_lockout_table
    import lflt_pkg::*;
#(
    parameter int unsigned ENTRIES = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [IP_W-1:0]   i_client_ip,
    input  wire logic [TIME_W-1:0] i_now_ms,
    input  wire logic              i_password_ok,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [1:0]        o_verdict,
    output logic      [SLOT_W-1:0] o_slot,
    output logic      [CNT_W-1:0]  o_fail_total
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    t_cfg cfg;

    lflt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_entry r_tbl [ENTRIES];
    logic [ENTRIES-1:0] r_vld;

    t_state r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_pass, n_pass;
    logic              r_claim, n_claim;
    logic              r_none, n_none;
    logic [IP_W-1:0]   r_ip;
    logic [TIME_W-1:0] r_now;
    logic              r_ok;
    t_entry            r_rd;
    logic              r_rd_vld;

    logic              r_out_valid;
    t_verdict          r_out_verdict, n_out_verdict;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [CNT_W-1:0]  r_out_total, n_out_total;

    t_entry            rd;
    logic [TIME_W-1:0] sub_b;
    logic [TIME_W-1:0] age;
    logic              out_free;
    logic              out_load;
    logic              accept;
    logic              wr_en;
    t_entry            wr_data;
    logic [CNT_W-1:0]  eff_cnt;
    logic [TIME_W-1:0] eff_last;
    logic              locked;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_ready;
    assign rd       = r_rd_vld ? r_rd : '0;

    // shared age unit
    assign eff_cnt  = r_claim ? '0 : rd.failures;
    assign eff_last = r_claim ? '0 : rd.last_fail;
    assign sub_b    = (r_state == S_DECIDE) ? eff_last : rd.last_fail;
    assign age      = r_now - sub_b;
    assign locked   = (eff_cnt >= cfg.fail_limit) &&
                      (age < TIME_W'(cfg.penalty_ms));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_pass      <= 1'b0;
            r_claim     <= 1'b0;
            r_none      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pass  <= n_pass;
            r_claim <= n_claim;
            r_none  <= n_none;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ip  <= i_client_ip;
            r_now <= i_now_ms;
            r_ok  <= i_password_ok;
        end
        if (out_load) begin
            r_out_verdict <= n_out_verdict;
            r_out_slot    <= n_out_slot;
            r_out_total   <= n_out_total;
        end
    end

    // table storage and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tbl[r_idx] <= wr_data;
        end
        r_rd <= r_tbl[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[r_idx] <= 1'b1;
            end
            r_rd_vld <= r_vld[r_idx];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_pass        = r_pass;
        n_claim       = r_claim;
        n_none        = r_none;
        out_load      = 1'b0;
        wr_en         = 1'b0;
        wr_data       = '{addr: r_ip, failures: eff_cnt, last_fail: eff_last};
        n_out_verdict = VERDICT_OK;
        n_out_slot    = SLOT_W'(r_idx);
        n_out_total   = eff_cnt;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                    n_idx   = '0;
                    n_pass  = 1'b0;
                    n_claim = 1'b0;
                    n_none  = 1'b0;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!r_pass) begin
                    if (rd.addr == r_ip) begin
                        n_state = S_DECIDE;
                    end else if (r_idx == IDX_LAST) begin
                        n_pass  = 1'b1;
                        n_idx   = '0;
                        n_state = S_READ;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end else begin
                    if ((rd.failures == '0) || (age > TIME_W'(cfg.stale_ms))) begin
                        n_claim = 1'b1;
                        n_state = S_DECIDE;
                    end else if (r_idx == IDX_LAST) begin
                        n_none  = 1'b1;
                        n_state = S_DECIDE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_DECIDE: begin
                if (r_none) begin
                    n_out_verdict = r_ok ? VERDICT_OK : VERDICT_WRONG;
                    n_out_slot    = SLOT_W'(ENTRIES);
                    n_out_total   = '0;
                end else if (locked) begin
                    n_out_verdict = VERDICT_LOCKED;
                end else if (r_ok) begin
                    n_out_verdict     = VERDICT_OK;
                    wr_data.failures  = '0;
                    wr_data.last_fail = '0;
                    n_out_total       = '0;
                end else begin
                    n_out_verdict     = VERDICT_WRONG;
                    wr_data.failures  = (eff_cnt == FAIL_SAT) ? eff_cnt : eff_cnt + 1'b1;
                    wr_data.last_fail = r_now;
                    n_out_total       = wr_data.failures;
                end
                if (out_free) begin
                    out_load = 1'b1;
                    wr_en    = !r_none;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_verdict    = r_out_verdict;
    assign o_slot       = r_out_slot;
    assign o_fail_total = r_out_total;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_LAST)
        else $error("scan index beyond table");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_state == S_READ && r_idx == '0 && !r_pass)
        else $error("scan did not start at entry zero");

    a_decide_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DECIDE && out_free |=> r_state == S_IDLE && o_valid)
        else $error("decision did not produce a word");

    a_ok_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_verdict == VERDICT_OK |-> o_fail_total == '0)
        else $error("accepted attempt with nonzero failure count");

    a_no_write_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !r_none && r_state == S_DECIDE)
        else $error("table written without an entry");

endmodule

`default_nettype wire

// ===== bench/tb_login_failure_lockout_table.sv =====
`default_nettype none

module tb_login_failure_lockout_table;
    import lflt_pkg::*;

    localparam int NUM_ENTRIES      = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 400000;

    typedef struct {
        logic [IP_W-1:0]   ip;
        logic [TIME_W-1:0] now;
        logic              ok;
    } t_attempt;

    typedef struct {
        t_verdict          verdict;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  fail_total;
    } t_judgment;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    wire  [DATA_W-1:0] prdata;
    wire               pready;
    logic              i_valid       = 1'b0;
    wire               o_ready;
    logic [IP_W-1:0]   i_client_ip   = '0;
    logic [TIME_W-1:0] i_now_ms      = '0;
    logic              i_password_ok = 1'b0;
    wire               o_valid;
    logic              i_ready       = 1'b0;
    wire  [1:0]        o_verdict;
    wire  [SLOT_W-1:0] o_slot;
    wire  [CNT_W-1:0]  o_fail_total;

    login_failure_lockout_table #(
        .ENTRIES(NUM_ENTRIES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_client_ip  (i_client_ip),
        .i_now_ms     (i_now_ms),
        .i_password_ok(i_password_ok),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_verdict    (o_verdict),
        .o_slot       (o_slot),
        .o_fail_total (o_fail_total)
    );

    // lockout table as the block should hold it
    logic [IP_W-1:0]   tbl_addr  [NUM_ENTRIES] = '{default: '0};
    logic [CNT_W-1:0]  tbl_count [NUM_ENTRIES] = '{default: '0};
    logic [TIME_W-1:0] tbl_last  [NUM_ENTRIES] = '{default: '0};
    logic [MS_W-1:0]   cfg_penalty = PENALTY_RST;
    logic [MS_W-1:0]   cfg_stale   = STALE_RST;
    logic [CNT_W-1:0]  cfg_limit   = LIMIT_RST;

    t_attempt  pending_attempts[$];
    t_judgment expected_judgments[$];
    t_attempt  next_attempt;
    t_judgment want;

    logic [TIME_W-1:0] gen_time = '0;
    bit idling         = 1'b1;
    bit attempt_taken  = 1'b0;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void judge_attempt(input logic [IP_W-1:0] ip,
                                          input logic [TIME_W-1:0] now, input logic ok);
        int hit;
        logic [TIME_W-1:0] age;
        t_judgment j;
        hit = -1;
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            if (hit < 0 && tbl_addr[k] == ip) begin
                hit = k;
            end
        end
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            age = now - tbl_last[k];
            if (hit < 0 && (tbl_count[k] == '0 || age > 32'(cfg_stale))) begin
                tbl_addr[k]  = ip;
                tbl_count[k] = '0;
                tbl_last[k]  = '0;
                hit = k;
            end
        end
        if (hit < 0) begin
            j.verdict    = ok ? VERDICT_OK : VERDICT_WRONG;
            j.slot       = SLOT_W'(NUM_ENTRIES);
            j.fail_total = '0;
        end else begin
            age    = now - tbl_last[hit];
            j.slot = SLOT_W'(hit);
            if (tbl_count[hit] >= cfg_limit && age < 32'(cfg_penalty)) begin
                j.verdict = VERDICT_LOCKED;
            end else if (ok) begin
                tbl_count[hit] = '0;
                tbl_last[hit]  = '0;
                j.verdict = VERDICT_OK;
            end else begin
                if (tbl_count[hit] != FAIL_SAT) begin
                    tbl_count[hit] = tbl_count[hit] + 1'b1;
                end
                tbl_last[hit] = now;
                j.verdict = VERDICT_WRONG;
            end
            j.fail_total = tbl_count[hit];
        end
        expected_judgments.push_back(j);
    endfunction

    // sender
    always @(posedge i_clk) begin
        attempt_taken = i_rst_n && i_valid && o_ready;
        if (attempt_taken) begin
            judge_attempt(i_client_ip, i_now_ms, i_password_ok);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || attempt_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 6);
                i_valid <= 1'b0;
            end else if (pending_attempts.size() > 0) begin
                next_attempt = pending_attempts.pop_front();
                i_client_ip   <= next_attempt.ip;
                i_now_ms      <= next_attempt.now;
                i_password_ok <= next_attempt.ok;
                i_valid       <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_judgments.size() == 0) begin
                $error("unexpected word: verdict %0d slot %0d fail_total %0d",
                       o_verdict, o_slot, o_fail_total);
                fail_count++;
            end else begin
                want = expected_judgments.pop_front();
                if (o_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, o_verdict);
                    fail_count++;
                end
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    fail_count++;
                end
                if (o_fail_total !== want.fail_total) begin
                    $error("fail_total: expected %0d, got %0d",
                           want.fail_total, o_fail_total);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (addr)
            ADDR_PENALTY: cfg_penalty = data[MS_W-1:0];
            ADDR_STALE:   cfg_stale   = data[MS_W-1:0];
            ADDR_LIMIT:   cfg_limit   = data[CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_attempts.size() != 0 || i_valid || expected_judgments.size() != 0);
    endtask

    task automatic set_limits(input logic [MS_W-1:0] pen, input logic [MS_W-1:0] stl,
                              input logic [CNT_W-1:0] lim);
        logic [DATA_W-1:0] data;
        wait_drained();
        data = $urandom;
        data[MS_W-1:0] = pen;
        reg_write(ADDR_PENALTY, data);
        data = $urandom;
        data[MS_W-1:0] = stl;
        reg_write(ADDR_STALE, data);
        data = $urandom;
        data[CNT_W-1:0] = lim;
        reg_write(ADDR_LIMIT, data);
    endtask

    task automatic add_attempt(input logic [IP_W-1:0] ip, input logic [TIME_W-1:0] now,
                               input logic ok);
        t_attempt a;
        a.ip  = ip;
        a.now = now;
        a.ok  = ok;
        pending_attempts.push_back(a);
    endtask

    // a few clients hammering with times that cross the penalty and stale edges
    task automatic queue_attempts(input int count, input int pool_size, input int ok_pct);
        logic [IP_W-1:0]   pool [8];
        logic [TIME_W-1:0] span_p;
        logic [TIME_W-1:0] span_s;
        logic [IP_W-1:0]   ip;
        int pick;
        for (int k = 0; k < pool_size; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                pool[k] = $urandom_range(0, 1) ? '1 : '0;
            end else begin
                pool[k] = $urandom;
            end
        end
        span_p = 32'(cfg_penalty) + 1;
        span_s = 32'(cfg_stale) + 1;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                gen_time += $urandom_range(0, span_p / 4 + 1);
            end else if (pick < 75) begin
                gen_time += $urandom_range(0, span_p + span_s);
            end else if (pick < 85) begin
                case ($urandom_range(0, 3))
                    0: gen_time += 32'(cfg_penalty) - 1;
                    1: gen_time += 32'(cfg_penalty);
                    2: gen_time += 32'(cfg_stale);
                    default: gen_time += 32'(cfg_stale) + 1;
                endcase
            end else if (pick < 93) begin
                gen_time = $urandom;
            end else begin
                gen_time = 32'hFFFF_FFFF - $urandom_range(0, span_p);
            end
            if ($urandom_range(0, 99) < 85) begin
                ip = pool[$urandom_range(0, pool_size - 1)];
            end else begin
                ip = $urandom;
            end
            add_attempt(ip, gen_time, $urandom_range(0, 99) < ok_pct);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset table matches address zero, lockout and its window edge
        add_attempt(32'h0000_0000, 32'h0000_0000, 1'b1);
        add_attempt(32'hFFFF_FFFF, 32'd100, 1'b0);
        add_attempt(32'hFFFF_FFFF, 32'd200, 1'b0);
        add_attempt(32'hFFFF_FFFF, 32'd300, 1'b0);
        add_attempt(32'hFFFF_FFFF, 32'd400, 1'b1);
        add_attempt(32'hFFFF_FFFF, 32'd5300, 1'b1);
        // lockout across the time wrap
        add_attempt(32'hC0A8_0001, 32'hFFFF_FFF0, 1'b0);
        add_attempt(32'hC0A8_0001, 32'hFFFF_FFF8, 1'b0);
        add_attempt(32'hC0A8_0001, 32'h0000_0000, 1'b0);
        add_attempt(32'hC0A8_0001, 32'h0000_0010, 1'b0);
        // full table, then no entry available
        add_attempt(32'h0A00_0002, 32'h0000_0020, 1'b0);
        add_attempt(32'h0A00_0003, 32'h0000_0030, 1'b0);
        add_attempt(32'h5555_AAAA, 32'h0000_0040, 1'b0);
        add_attempt(32'hAAAA_5555, 32'h0000_0050, 1'b0);
        add_attempt(32'hAAAA_5555, 32'h0000_0060, 1'b1);
        // stale reclaim past the age edge
        add_attempt(32'hAAAA_5555, 32'h0000_0040 + 32'd60000, 1'b0);
        add_attempt(32'hC0A8_0001, 32'h0000_0040 + 32'd60000, 1'b1);
        add_attempt(32'h0000_0000, 32'h0000_0050 + 32'd60000, 1'b0);
        gen_time = 32'h0001_0000;

        // repeated failures by one pooled client, never locked with a zero window
        set_limits('0, '0, 8'd1);
        queue_attempts(260, 1, 0);

        set_limits(20'd600000, 20'd600000, 8'd255);
        queue_attempts(120, 5, 30);

        set_limits('1, '1, 8'd1);
        queue_attempts(120, 6, 30);
        hold_requests++;

        set_limits(MS_W'($urandom_range(0, 2000)), '0, '0);
        queue_attempts(120, 4, 30);

        set_limits('0, MS_W'($urandom_range(0, 600000)), CNT_W'($urandom_range(1, 255)));
        queue_attempts(100, 5, 30);

        repeat (3) begin
            set_limits(MS_W'($urandom_range(0, 600000)), MS_W'($urandom_range(0, 600000)),
                       CNT_W'($urandom_range(1, 8)));
            queue_attempts(120, $urandom_range(2, 7), 30);
        end

        wait_drained();
        idling = 1'b0;
        set_limits(PENALTY_RST, STALE_RST, LIMIT_RST);
        queue_attempts(150, 5, 30);

        wait_drained();
        repeat (4 * NUM_ENTRIES + 4) @(posedge i_clk);
        if (fail_count == 0 && expected_judgments.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
